// ----- src/tdh_pkg.sv -----
// ----------------------------------------------------------------------------
// tdh_pkg - shared types and codes for the timer deadline heap
// Slot record, command/status codes and the controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package tdh_pkg;

  localparam int TID_W       = 6;
  localparam int DL_W        = 32;
  localparam int SLOT_W      = TID_W + DL_W;
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [DL_W-1:0] MAX_WAIT_RST = 32'd1000;

  // One heap slot: owning timer and its deadline.
  typedef struct packed {
    logic [TID_W-1:0] tid;
    logic [DL_W-1:0]  dl;
  } slot_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_EXPIRE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_INACTIVE = 2'd2,
    STAT_NONE_DUE = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_POS,
    S_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_EXP
  } state_t;

endpackage

`default_nettype wire

// ----- src/tdh_ram.sv -----
// ----------------------------------------------------------------------------
// tdh_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/tdh_level.sv -----
// ----------------------------------------------------------------------------
// tdh_level - one heap level cell
// Holds the slots of one tree level as sibling pairs (even/odd lane), so
// both children of a node come out in one read beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tdh_level #(
  parameter int PAIR_DEPTH = 1,
  localparam int AW        = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_pair,
  input  wire logic                  wr_en,
  input  wire logic                  wr_lane,
  input  wire logic [AW-1:0]         wr_pair,
  input  wire tdh_pkg::slot_t        wr_data,
  output tdh_pkg::slot_t [1:0]       rd_data
);

  for (genvar g = 0; g < 2; g++) begin : g_lane
    tdh_ram #(
      .WIDTH (tdh_pkg::SLOT_W),
      .DEPTH (PAIR_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en && (wr_lane == 1'(g))),
      .waddr (wr_pair),
      .wdata (wr_data),
      .re    (rd_en),
      .raddr (rd_pair),
      .rdata (rd_data[g])
    );
  end

endmodule

`default_nettype wire

// ----- src/timer_deadline_heap.sv -----
// ----------------------------------------------------------------------------
// timer_deadline_heap - binary min-heap of timer deadlines
// Insert, cancel, expire-due and query-wait over a heap kept as a chain of
// level cells, with a per-timer position table so any timer can be removed.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  command  | in_command in_timer_id in_deadline      | beat taken: start & !busy
//           | in_now_time                             |
//  result   | out_timer_id_out out_status             | out_valid, one cycle,
//           | out_became_earliest out_wait_ticks      | no backpressure
//           | out_last                                |
//  config   | cfg_wr_en cfg_wr_data (max_wait)        | written when cfg_wr_en
//
//  Sequence: a query (or an out-of-range timer id) answers the cycle after the
//  beat and leaves busy low. Active/full insert and inactive cancel answer from
//  the position read (S_POS). Insert then climbs a parent read and compare
//  (S_UP_RD, S_UP_CMP) per level and places the timer. Cancel takes the last
//  slot (S_LAST), sifts it up or down a read and compare per level and places
//  it. Expire pops each due timer from the root the same way, then gives the
//  final beat in S_EXP. Reset: a clearing pass (S_CLEAR) marks every timer
//  inactive; busy is high during it. The receiver cannot stall; each result
//  is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_deadline_heap #(
  parameter int HEAP_DEPTH  = 64,
  parameter int TIMER_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [5:0]  in_timer_id,
  input  wire logic [31:0] in_deadline,
  input  wire logic [31:0] in_now_time,
  // result channel
  output logic             out_valid,
  output logic [5:0]       out_timer_id_out,
  output logic [1:0]       out_status,
  output logic             out_became_earliest,
  output logic [31:0]      out_wait_ticks,
  output logic             out_last,
  // config
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  // count / position width; HEAP_DEPTH in a position means inactive
  localparam int CW     = $clog2(HEAP_DEPTH + 1);
  // 1-based node numbers, room for 2n+1
  localparam int NW     = $clog2(2 * HEAP_DEPTH + 2);
  localparam int LEVELS = $clog2(HEAP_DEPTH + 1);
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int HPW    = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int PAW    = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  // --------------------------------------------------------------------------
  // node helpers: level = msb of node, offset = node with msb cleared
  // --------------------------------------------------------------------------
  function automatic logic [LW-1:0] node_level(input logic [NW-1:0] n);
    logic [LW-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < NW; i++) begin
      if (n[i]) lvl = LW'(i);
    end
    return lvl;
  endfunction

  function automatic logic [NW-1:0] node_off(input logic [NW-1:0] n);
    return n ^ (NW'(1) << node_level(n));
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  tdh_pkg::state_t        state_r, state_nxt;
  tdh_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [5:0]             tid_r, tid_nxt;
  logic [31:0]            dl_r, dl_nxt;
  logic [31:0]            now_r, now_nxt;
  logic [31:0]            max_wait_r;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [NW-1:0]          node_r, node_nxt;
  tdh_pkg::slot_t         item_r, item_nxt;
  logic                   first_r, first_nxt;
  logic [tdh_pkg::RES_W-1:0] nres_r, nres_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [5:0]             pend_tid_r, pend_tid_nxt;
  tdh_pkg::slot_t         root_r;
  logic [PAW-1:0]         clr_r, clr_nxt;
  logic [LW-1:0]          rd_lvl_r;
  logic                   rd_lane_r;

  logic                   out_valid_r;
  logic [5:0]             out_tid_r;
  tdh_pkg::stat_t         out_stat_r;
  logic                   out_be_r;
  logic [31:0]            out_wait_r;
  logic                   out_last_r;

  // --------------------------------------------------------------------------
  // memory access controls
  // --------------------------------------------------------------------------
  logic                   hrd_en, hrd_child;
  logic [NW-1:0]          hrd_node;
  logic                   hwr_en;
  logic [NW-1:0]          hwr_node;
  tdh_pkg::slot_t         hwr_data;

  logic [LW-1:0]          rd_lvl, wr_lvl;
  logic [NW-1:0]          rd_off, wr_off;
  logic [HPW-1:0]         rd_pair, wr_pair;
  logic                   rd_lane, wr_lane;

  logic                   pos_re;
  logic                   pwr_en;
  logic [PAW-1:0]         pwr_addr;
  logic [CW-1:0]          pwr_data;
  logic [CW-1:0]          pos_rdata;

  tdh_pkg::slot_t [1:0]   cell_rd [LEVELS];
  tdh_pkg::slot_t [1:0]   rd_pair_data;
  tdh_pkg::slot_t         rd_slot;

  // emit controls
  logic                   emit;
  logic [5:0]             e_tid;
  tdh_pkg::stat_t         e_stat;
  logic                   e_be;
  logic [31:0]            e_wait;
  logic                   e_last;

  // misc comb
  logic                   place;
  logic                   in_id_ok;
  logic                   pos_active;
  logic [NW-1:0]          rm_node;
  logic [5:0]             victim;
  logic                   remove;
  logic [31:0]            q_diff;
  logic [31:0]            q_wait;
  logic [NW-1:0]          child;
  logic                   pick_odd;
  tdh_pkg::slot_t         best_child;
  logic                   due;

  assign in_id_ok = 32'(in_timer_id) < TIMER_COUNT;
  assign pos_active = pos_rdata < cnt_r;
  assign child = node_r << 1;

  // query wait from the root shadow
  assign q_diff = root_r.dl - in_now_time;
  always_comb begin
    if (cnt_r == '0) begin
      q_wait = max_wait_r;
    end else if (root_r.dl <= in_now_time) begin
      q_wait = '0;
    end else if (q_diff > max_wait_r) begin
      q_wait = max_wait_r;
    end else begin
      q_wait = q_diff;
    end
  end

  // heap read data: level picked by registered level, lane by registered lane
  assign rd_pair_data = cell_rd[rd_lvl_r];
  assign rd_slot      = rd_pair_data[rd_lane_r];

  // smaller child; ties go to the left child
  assign pick_odd   = ((child + NW'(1)) <= NW'(cnt_r)) &&
                      (rd_pair_data[1].dl < rd_pair_data[0].dl);
  assign best_child = pick_odd ? rd_pair_data[1] : rd_pair_data[0];

  assign due = (cnt_r != '0) && !(now_r < root_r.dl) &&
               (nres_r < tdh_pkg::RES_W'(tdh_pkg::MAX_RESULTS));

  // --------------------------------------------------------------------------
  // controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    tid_nxt      = tid_r;
    dl_nxt       = dl_r;
    now_nxt      = now_r;
    cnt_nxt      = cnt_r;
    node_nxt     = node_r;
    item_nxt     = item_r;
    first_nxt    = first_r;
    nres_nxt     = nres_r;
    pend_v_nxt   = pend_v_r;
    pend_tid_nxt = pend_tid_r;
    clr_nxt      = clr_r;

    hrd_en    = 1'b0;
    hrd_child = 1'b0;
    hrd_node  = '0;
    hwr_en    = 1'b0;
    hwr_node  = node_r;
    hwr_data  = item_r;
    pos_re    = 1'b0;
    pwr_en    = 1'b0;
    pwr_addr  = '0;
    pwr_data  = '0;

    emit   = 1'b0;
    e_tid  = tid_r;
    e_stat = tdh_pkg::STAT_OK;
    e_be   = 1'b0;
    e_wait = '0;
    e_last = 1'b1;

    place   = 1'b0;
    remove  = 1'b0;
    rm_node = NW'(1);
    victim  = tid_r;

    case (state_r)
      tdh_pkg::S_CLEAR: begin
        pwr_en   = 1'b1;
        pwr_addr = clr_r;
        pwr_data = CW'(HEAP_DEPTH);
        clr_nxt  = clr_r + PAW'(1);
        if (clr_r == PAW'(TIMER_COUNT - 1)) begin
          state_nxt = tdh_pkg::S_IDLE;
        end
      end

      tdh_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt = tdh_pkg::cmd_t'(in_command);
          tid_nxt = in_timer_id;
          dl_nxt  = in_deadline;
          now_nxt = in_now_time;
          case (tdh_pkg::cmd_t'(in_command))
            tdh_pkg::CMD_INSERT, tdh_pkg::CMD_CANCEL: begin
              if (!in_id_ok) begin
                emit   = 1'b1;
                e_tid  = in_timer_id;
                e_stat = tdh_pkg::STAT_INACTIVE;
              end else begin
                pos_re    = 1'b1;
                state_nxt = tdh_pkg::S_POS;
              end
            end
            tdh_pkg::CMD_EXPIRE: begin
              nres_nxt   = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = tdh_pkg::S_EXP;
            end
            default: begin
              emit   = 1'b1;
              e_tid  = (cnt_r == '0) ? 6'd0 : root_r.tid;
              e_wait = q_wait;
            end
          endcase
        end
      end

      tdh_pkg::S_POS: begin
        if (cmd_r == tdh_pkg::CMD_INSERT) begin
          if (pos_active) begin
            emit      = 1'b1;
            state_nxt = tdh_pkg::S_IDLE;
          end else if (cnt_r == CW'(HEAP_DEPTH)) begin
            emit      = 1'b1;
            e_stat    = tdh_pkg::STAT_FULL;
            state_nxt = tdh_pkg::S_IDLE;
          end else begin
            item_nxt  = '{tid: tid_r, dl: dl_r};
            node_nxt  = NW'(cnt_r) + NW'(1);
            cnt_nxt   = cnt_r + CW'(1);
            first_nxt = 1'b0;
            state_nxt = tdh_pkg::S_UP_RD;
          end
        end else if (!pos_active) begin
          emit      = 1'b1;
          e_stat    = tdh_pkg::STAT_INACTIVE;
          state_nxt = tdh_pkg::S_IDLE;
        end else begin
          remove  = 1'b1;
          rm_node = NW'(pos_rdata) + NW'(1);
        end
      end

      tdh_pkg::S_LAST: begin
        // last slot becomes the item refilling the hole
        item_nxt  = rd_slot;
        pwr_en    = 1'b1;
        pwr_addr  = PAW'(tid_r);
        pwr_data  = CW'(HEAP_DEPTH);
        cnt_nxt   = cnt_r - CW'(1);
        first_nxt = 1'b1;
        state_nxt = tdh_pkg::S_UP_RD;
      end

      tdh_pkg::S_UP_RD: begin
        if (node_r == NW'(1)) begin
          if (first_r) state_nxt = tdh_pkg::S_DN_RD;
          else         place     = 1'b1;
        end else begin
          hrd_en    = 1'b1;
          hrd_node  = node_r >> 1;
          state_nxt = tdh_pkg::S_UP_CMP;
        end
      end

      tdh_pkg::S_UP_CMP: begin
        if (item_r.dl < rd_slot.dl) begin
          hwr_en    = 1'b1;
          hwr_data  = rd_slot;
          pwr_en    = 1'b1;
          pwr_addr  = PAW'(rd_slot.tid);
          pwr_data  = CW'(node_r - NW'(1));
          node_nxt  = node_r >> 1;
          first_nxt = 1'b0;
          state_nxt = tdh_pkg::S_UP_RD;
        end else if (first_r) begin
          state_nxt = tdh_pkg::S_DN_RD;
        end else begin
          place = 1'b1;
        end
      end

      tdh_pkg::S_DN_RD: begin
        if (child > NW'(cnt_r)) begin
          place = 1'b1;
        end else begin
          hrd_en    = 1'b1;
          hrd_child = 1'b1;
          hrd_node  = node_r;
          state_nxt = tdh_pkg::S_DN_CMP;
        end
      end

      tdh_pkg::S_DN_CMP: begin
        if (item_r.dl < best_child.dl) begin
          place = 1'b1;
        end else begin
          hwr_en    = 1'b1;
          hwr_data  = best_child;
          pwr_en    = 1'b1;
          pwr_addr  = PAW'(best_child.tid);
          pwr_data  = CW'(node_r - NW'(1));
          node_nxt  = pick_odd ? (child + NW'(1)) : child;
          state_nxt = tdh_pkg::S_DN_RD;
        end
      end

      tdh_pkg::S_EXP: begin
        // a popped timer is held back one step so its last flag is known
        if (due) begin
          if (pend_v_r) begin
            emit   = 1'b1;
            e_tid  = pend_tid_r;
            e_last = 1'b0;
          end
          pend_v_nxt   = 1'b1;
          pend_tid_nxt = root_r.tid;
          tid_nxt      = root_r.tid;
          nres_nxt     = nres_r + tdh_pkg::RES_W'(1);
          remove       = 1'b1;
          rm_node      = NW'(1);
          victim       = root_r.tid;
        end else begin
          emit = 1'b1;
          if (pend_v_r) begin
            e_tid = pend_tid_r;
          end else begin
            e_tid  = 6'd0;
            e_stat = tdh_pkg::STAT_NONE_DUE;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = tdh_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tdh_pkg::S_IDLE;
      end
    endcase

    // take a timer out of node rm_node
    if (remove) begin
      if (rm_node == NW'(cnt_r)) begin
        pwr_en   = 1'b1;
        pwr_addr = PAW'(victim);
        pwr_data = CW'(HEAP_DEPTH);
        cnt_nxt  = cnt_r - CW'(1);
        if (cmd_r == tdh_pkg::CMD_EXPIRE) begin
          state_nxt = tdh_pkg::S_EXP;
        end else begin
          emit      = 1'b1;
          state_nxt = tdh_pkg::S_IDLE;
        end
      end else begin
        hrd_en    = 1'b1;
        hrd_node  = NW'(cnt_r);
        node_nxt  = rm_node;
        state_nxt = tdh_pkg::S_LAST;
      end
    end

    // final placement of the sifted item
    if (place) begin
      hwr_en   = 1'b1;
      hwr_data = item_r;
      pwr_en   = 1'b1;
      pwr_addr = PAW'(item_r.tid);
      pwr_data = CW'(node_r - NW'(1));
      if (cmd_r == tdh_pkg::CMD_EXPIRE) begin
        state_nxt = tdh_pkg::S_EXP;
      end else begin
        emit      = 1'b1;
        e_be      = (cmd_r == tdh_pkg::CMD_INSERT) && (node_r == NW'(1));
        state_nxt = tdh_pkg::S_IDLE;
      end
    end
  end

  // node -> level cell, pair and lane
  always_comb begin
    wr_lvl  = node_level(hwr_node);
    wr_off  = node_off(hwr_node);
    wr_lane = wr_off[0];
    wr_pair = HPW'(wr_off >> 1);
    rd_off  = node_off(hrd_node);
    if (hrd_child) begin
      rd_lvl  = node_level(hrd_node) + LW'(1);
      rd_pair = HPW'(rd_off);
      rd_lane = 1'b0;
    end else begin
      rd_lvl  = node_level(hrd_node);
      rd_pair = HPW'(rd_off >> 1);
      rd_lane = rd_off[0];
    end
  end

  // --------------------------------------------------------------------------
  // level cells and position table
  // --------------------------------------------------------------------------
  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    localparam int PD  = (l == 0) ? 1 : (1 << (l - 1));
    localparam int CAW = (PD > 1) ? $clog2(PD) : 1;
    tdh_level #(
      .PAIR_DEPTH (PD)
    ) u_level (
      .clk     (clk),
      .rd_en   (hrd_en && (rd_lvl == LW'(l))),
      .rd_pair (CAW'(rd_pair)),
      .wr_en   (hwr_en && (wr_lvl == LW'(l))),
      .wr_lane (wr_lane),
      .wr_pair (CAW'(wr_pair)),
      .wr_data (hwr_data),
      .rd_data (cell_rd[l])
    );
  end

  tdh_ram #(
    .WIDTH (CW),
    .DEPTH (TIMER_COUNT)
  ) u_pos (
    .clk   (clk),
    .we    (pwr_en),
    .waddr (pwr_addr),
    .wdata (pwr_data),
    .re    (pos_re),
    .raddr (PAW'(in_timer_id)),
    .rdata (pos_rdata)
  );

  // --------------------------------------------------------------------------
  // sequential
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdh_pkg::S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      max_wait_r  <= tdh_pkg::MAX_WAIT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= emit;
      if (cfg_wr_en) max_wait_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tid_r      <= tid_nxt;
    dl_r       <= dl_nxt;
    now_r      <= now_nxt;
    node_r     <= node_nxt;
    item_r     <= item_nxt;
    first_r    <= first_nxt;
    nres_r     <= nres_nxt;
    pend_tid_r <= pend_tid_nxt;
    if (hwr_en && (hwr_node == NW'(1))) root_r <= hwr_data;
    if (hrd_en) begin
      rd_lvl_r  <= rd_lvl;
      rd_lane_r <= rd_lane;
    end
    if (emit) begin
      out_tid_r  <= e_tid;
      out_stat_r <= e_stat;
      out_be_r   <= e_be;
      out_wait_r <= e_wait;
      out_last_r <= e_last;
    end
  end

  assign busy                = (state_r != tdh_pkg::S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_timer_id_out    = out_tid_r;
  assign out_status          = out_stat_r;
  assign out_became_earliest = out_be_r;
  assign out_wait_ticks      = out_wait_r;
  assign out_last            = out_last_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HEAP_DEPTH))
    else $error("heap count above depth");

  a_query_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == tdh_pkg::CMD_QUERY)) |=> (out_valid && out_last))
    else $error("query beat without a result");

  a_none_due: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == tdh_pkg::STAT_NONE_DUE)) |->
      (out_last && (out_timer_id_out == 6'd0)))
    else $error("nothing-due result malformed");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdh_pkg::S_IDLE) |-> !pend_v_r)
    else $error("expire result left pending");

endmodule

`default_nettype wire
